[rtl/swms_pkg.sv]
// ----------------------------------------------------------------------------
// swms_pkg: shared definitions for the signed word merge sorter
// Batch capacity, derived index widths and the run-bound clamp used when
// a merge run is set up.
// ----------------------------------------------------------------------------
`default_nettype none

package swms_pkg;

    localparam int WORD_W = 32;
    localparam int DEPTH  = 64;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    // Room for lo + 4 * width without wrapping.
    localparam int SPAN_W = CNT_W + 2;

    // Limit a run bound to the number of stored elements.
    function automatic logic [CNT_W-1:0] clamp_bound(input logic [SPAN_W-1:0] x,
                                                     input logic [CNT_W-1:0]  n);
        logic [CNT_W-1:0] r;
        if (x > SPAN_W'(n))
            r = n;
        else
            r = x[CNT_W-1:0];
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/signed_word_merge_sorter.sv]
// ----------------------------------------------------------------------------
// signed_word_merge_sorter
// Collects a batch of signed words, sorts it with a bottom-up merge sort that
// ping-pongs between two on-chip memories, and streams it out in ascending
// order.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake            Payload
//  -------  -------------------  -------------------------------------
//  input    in_valid / in_stall  value[31:0], last
//  output   out_valid/out_stall  sorted_value[31:0], final_res, overflow
//
// Loading accepts one transfer per cycle. Closing a batch of n elements starts
// ceil(log2 n) merge passes, each writing through the single write port of the
// destination memory, and then streams the results out. Reset clears the
// control state only; the memories are not cleared.
// in_stall stays high from the closing transfer until the last result is in
// the output register; a stalled output holds emission without losing data.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_word_merge_sorter
(
    input  wire  logic                              clk,
    input  wire  logic                              rst_n,
    input  wire  logic                              in_valid,
    output logic                                    in_stall,
    input  wire  logic signed [swms_pkg::WORD_W-1:0] value,
    input  wire  logic                              last,
    output logic                                    out_valid,
    input  wire  logic                              out_stall,
    output logic signed [swms_pkg::WORD_W-1:0]      sorted_value,
    output logic                                    final_res,
    output logic                                    overflow
);

    import swms_pkg::*;

    typedef enum logic [2:0]
    {
        S_LOAD,
        S_PRIME,
        S_MERGE,
        S_EMIT_PRIME,
        S_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [CNT_W-1:0]  w_reg, w_next;
    logic [CNT_W-1:0]  lo_reg, lo_next;
    logic [CNT_W-1:0]  mid_reg, mid_next;
    logic [CNT_W-1:0]  hi_reg, hi_next;
    logic [CNT_W-1:0]  a_reg, a_next;
    logic [CNT_W-1:0]  b_reg, b_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [CNT_W-1:0]  e_reg, e_next;
    logic              src_reg, src_next;

    logic              out_valid_reg, out_valid_next;
    logic [WORD_W-1:0] out_value_reg, out_value_next;
    logic              out_final_reg, out_final_next;
    logic              out_ovf_reg, out_ovf_next;

    // Two memories: the store (bank 0) and the merge scratch (bank 1).
    logic [WORD_W-1:0] store_mem [DEPTH];
    logic [WORD_W-1:0] scratch_mem [DEPTH];
    logic [WORD_W-1:0] s_qa_reg, s_qb_reg, m_qa_reg, m_qb_reg;

    logic              we0, we1;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] rd_a, rd_b;

    logic [WORD_W-1:0] cur_qa, cur_qb;
    logic              in_take, out_free, load_full, take_a, run_end;
    logic [CNT_W-1:0]  load_n;
    logic [SPAN_W-1:0] w_dbl, w_quad, lo_step;
    logic [CNT_W-1:0]  next_mid;

    assign in_stall     = (state_reg != S_LOAD);
    assign out_valid    = out_valid_reg;
    assign sorted_value = out_value_reg;
    assign final_res    = out_final_reg;
    assign overflow     = out_ovf_reg;

    assign in_take   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign load_full = (count_reg == CNT_W'(DEPTH));
    assign load_n    = load_full ? count_reg : count_reg + CNT_W'(1);

    assign cur_qa = src_reg ? m_qa_reg : s_qa_reg;
    assign cur_qb = src_reg ? m_qb_reg : s_qb_reg;

    assign w_dbl    = SPAN_W'(w_reg) << 1;
    assign w_quad   = SPAN_W'(w_reg) << 2;
    assign lo_step  = SPAN_W'(lo_reg) + w_dbl;
    assign next_mid = clamp_bound(lo_step + SPAN_W'(w_reg), count_reg);

    // Take from the left run on ties too; equal words are indistinguishable.
    assign take_a  = (a_reg < mid_reg) &&
                     ((b_reg >= hi_reg) || !($signed(cur_qb) < $signed(cur_qa)));
    assign run_end = ((k_reg + CNT_W'(1)) == hi_reg);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        w_next         = w_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        k_next         = k_reg;
        e_next         = e_reg;
        src_next       = src_reg;
        out_valid_next = out_valid_reg;
        out_value_next = out_value_reg;
        out_final_next = out_final_reg;
        out_ovf_next   = out_ovf_reg;
        we0            = 1'b0;
        we1            = 1'b0;
        waddr          = count_reg[ADDR_W-1:0];
        wdata          = value;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                if (in_take)
                begin
                    if (!load_full)
                    begin
                        we0        = 1'b1;
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last)
                    begin
                        src_next = 1'b0;
                        e_next   = '0;
                        if (load_n >= CNT_W'(2))
                        begin
                            w_next     = CNT_W'(1);
                            lo_next    = '0;
                            mid_next   = CNT_W'(1);
                            hi_next    = CNT_W'(2);
                            a_next     = '0;
                            b_next     = CNT_W'(1);
                            k_next     = '0;
                            state_next = S_PRIME;
                        end
                        else
                        begin
                            state_next = S_EMIT_PRIME;
                        end
                    end
                end
            end

            S_PRIME:
            begin
                state_next = S_MERGE;
            end

            S_MERGE:
            begin
                we0   = src_reg;
                we1   = !src_reg;
                waddr = k_reg[ADDR_W-1:0];
                wdata = take_a ? cur_qa : cur_qb;
                if (run_end)
                begin
                    if (lo_step >= SPAN_W'(count_reg))
                    begin
                        // The pass is complete; the destination becomes the source.
                        src_next = !src_reg;
                        if (w_dbl >= SPAN_W'(count_reg))
                        begin
                            e_next     = '0;
                            state_next = S_EMIT_PRIME;
                        end
                        else
                        begin
                            w_next     = w_dbl[CNT_W-1:0];
                            lo_next    = '0;
                            mid_next   = clamp_bound(w_dbl, count_reg);
                            hi_next    = clamp_bound(w_quad, count_reg);
                            a_next     = '0;
                            b_next     = clamp_bound(w_dbl, count_reg);
                            k_next     = '0;
                            state_next = S_PRIME;
                        end
                    end
                    else
                    begin
                        lo_next  = lo_step[CNT_W-1:0];
                        mid_next = next_mid;
                        hi_next  = clamp_bound(lo_step + w_dbl, count_reg);
                        a_next   = lo_step[CNT_W-1:0];
                        b_next   = next_mid;
                        k_next   = k_reg + CNT_W'(1);
                    end
                end
                else
                begin
                    if (take_a)
                        a_next = a_reg + CNT_W'(1);
                    else
                        b_next = b_reg + CNT_W'(1);
                    k_next = k_reg + CNT_W'(1);
                end
            end

            S_EMIT_PRIME:
            begin
                state_next = S_EMIT;
            end

            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = cur_qa;
                    out_final_next = ((e_reg + CNT_W'(1)) == count_reg);
                    out_ovf_next   = ovf_reg;
                    e_next         = e_reg + CNT_W'(1);
                    if ((e_reg + CNT_W'(1)) == count_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Read addresses follow the next pointers so that the registered read data
    // always holds the words at the current pointers.
    assign rd_a = ((state_reg == S_EMIT) || (state_reg == S_EMIT_PRIME)) ?
                  e_next[ADDR_W-1:0] : a_next[ADDR_W-1:0];
    assign rd_b = b_next[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        if (we0)
        begin
            store_mem[waddr] <= wdata;
        end
        s_qa_reg <= store_mem[rd_a];
        s_qb_reg <= store_mem[rd_b];
    end

    always_ff @(posedge clk)
    begin
        if (we1)
        begin
            scratch_mem[waddr] <= wdata;
        end
        m_qa_reg <= scratch_mem[rd_a];
        m_qb_reg <= scratch_mem[rd_b];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            w_reg         <= '0;
            lo_reg        <= '0;
            mid_reg       <= '0;
            hi_reg        <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            k_reg         <= '0;
            e_reg         <= '0;
            src_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_final_reg <= 1'b0;
            out_ovf_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            w_reg         <= w_next;
            lo_reg        <= lo_next;
            mid_reg       <= mid_next;
            hi_reg        <= hi_next;
            a_reg         <= a_next;
            b_reg         <= b_next;
            k_reg         <= k_next;
            e_reg         <= e_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
            out_value_reg <= out_value_next;
            out_final_reg <= out_final_next;
            out_ovf_reg   <= out_ovf_next;
        end
    end

    // Every word written in a merge came from one of the two runs.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |->
        (SPAN_W'(k_reg) + SPAN_W'(mid_reg) == SPAN_W'(a_reg) + SPAN_W'(b_reg)))
        else $error("merge output index out of step with run pointers");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MERGE) |-> (a_reg <= mid_reg && b_reg <= hi_reg))
        else $error("merge pointer ran past its run");

    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (count_reg == CNT_W'(DEPTH)))
        else $error("overflow flagged while the store is not full");

    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count beyond capacity");

endmodule

`default_nettype wire
